### src/teg_pkg.sv
// ----------------------------------------------------------------------------
// teg_pkg: shared types and constants for the thermal erosion grid pass unit
// Holds operation codes, the sequencer state type and the parameter defaults.
// ----------------------------------------------------------------------------
package teg_pkg;

	localparam int unsigned DEF_MAX_COLUMNS = 128;
	localparam int unsigned DEF_MAX_ROWS    = 128;
	localparam int unsigned DEF_HEIGHT_BITS = 32;

	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned INDEX_W  = 14;
	localparam int unsigned IO_H_W   = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;
	localparam int unsigned LIMIT_W  = 31;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_RUN   = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMNS = 3'd0,
		REG_ROWS    = 3'd1,
		REG_LIM_ORT = 3'd2,
		REG_LIM_DIA = 3'd3,
		REG_PASSES  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_RD_DATA,
		ST_PASS_START,
		ST_CELL_REQ,
		ST_CELL_WAIT,
		ST_CELL_LOAD,
		ST_NB_REQ,
		ST_NB_WAIT,
		ST_NB_ACC,
		ST_CELL_WRITE,
		ST_COPY_REQ,
		ST_COPY_WAIT,
		ST_COPY_WRITE,
		ST_PASS_END,
		ST_RESPOND
	} state_t;

endpackage

### src/teg_if.sv
// ----------------------------------------------------------------------------
// teg_if: channel interfaces
// Command, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface teg_cmd_if import teg_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [FUNC_W-1:0]         func;
	logic [INDEX_W-1:0]        cell_index;
	logic signed [IO_H_W-1:0]  height_in;
	modport source (output valid, func, cell_index, height_in, input ready);
	modport sink (input valid, func, cell_index, height_in, output ready);
endinterface

interface teg_rsp_if import teg_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [IO_H_W-1:0]  height_out;
	logic                      op_done;
	modport source (output valid, height_out, op_done, input ready);
	modport sink (input valid, height_out, op_done, output ready);
endinterface

interface teg_cfg_if import teg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DAT_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/teg_ram.sv
// ----------------------------------------------------------------------------
// teg_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module teg_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### src/thermal_erosion_grid_pass_unit.sv
// ----------------------------------------------------------------------------
// thermal_erosion_grid_pass_unit: talus-angle thermal erosion on a height grid
//
// Channels: cmd (func, cell_index, height_in), rsp (height_out, op_done) and
// cfg (index, data) for the five control registers; the user is to write
// them only while idle, which the block itself does not enforce. Every
// accepted command yields exactly one response transfer. A write goes from
// idle straight to the response; a read first passes ST_RD_WAIT and
// ST_RD_DATA. In a run every cell and every neighbor height is fetched
// through the single read port of the frozen bank, and one shared adder
// accumulates the flows; neighbor positions past the top or bottom row are
// skipped. Cells beyond columns*rows are copied to the new bank.
// cmd.ready is high only in idle; one command is worked on at a time.
// The response waits in an output register until rsp.ready; the block holds
// until it is taken. Reset selects bank a and loads register defaults; bank
// contents are undefined until written.
// ----------------------------------------------------------------------------
module thermal_erosion_grid_pass_unit import teg_pkg::*; #(
	parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
	parameter int unsigned HEIGHT_BITS = DEF_HEIGHT_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	teg_cmd_if.sink    cmd,
	teg_rsp_if.source  rsp,
	teg_cfg_if.sink    cfg
);
	localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(MAX_COLUMNS + 1);
	localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
	localparam int unsigned ACC_W = HEIGHT_BITS + 5;
	localparam int unsigned DIF_W = HEIGHT_BITS + 2;

	// configuration
	logic [7:0]         cols_q, rows_q, passes_q;
	logic [LIMIT_W-1:0] lim_o_q, lim_d_q;
	logic               bank_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= 8'd128;
			rows_q   <= 8'd128;
			lim_o_q  <= LIMIT_W'(256);
			lim_d_q  <= LIMIT_W'(362);
			passes_q <= 8'd1;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_COLUMNS: cols_q   <= cfg.data[7:0];
				REG_ROWS:    rows_q   <= cfg.data[7:0];
				REG_LIM_ORT: lim_o_q  <= cfg.data[LIMIT_W-1:0];
				REG_LIM_DIA: lim_d_q  <= cfg.data[LIMIT_W-1:0];
				REG_PASSES:  passes_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// active dimensions, clamped to 1..max
	logic [CW-1:0] act_cols;
	logic [RW-1:0] act_rows;
	logic [AW:0]   act_cells;
	always_comb begin
		if (cols_q == 8'd0) act_cols = CW'(1);
		else if (32'(cols_q) > MAX_COLUMNS) act_cols = CW'(MAX_COLUMNS);
		else act_cols = CW'(cols_q);
		if (rows_q == 8'd0) act_rows = RW'(1);
		else if (32'(rows_q) > MAX_ROWS) act_rows = RW'(MAX_ROWS);
		else act_rows = RW'(rows_q);
	end

	// sequencer registers
	state_t state_q, state_d;
	logic [INDEX_W-1:0]         idx_q;
	logic [7:0]                 pass_q;
	logic [RW-1:0]              r_q;
	logic [CW-1:0]              c_q;
	logic [AW:0]                lin_q;     // raster index of the cell, also copy index
	logic [3:0]                 nb_q;      // neighbor 0..8, skipping center 4
	logic signed [HEIGHT_BITS-1:0] here_q;
	logic signed [ACC_W-1:0]    net_q;
	logic signed [IO_H_W-1:0]   hout_q;
	logic                       done_q;

	assign act_cells = (AW+1)'(act_cols * act_rows);

	// neighbor geometry
	logic [1:0] dr, dc;
	assign dr = (nb_q < 4'd3) ? 2'd0 : (nb_q < 4'd6) ? 2'd1 : 2'd2;
	assign dc = 2'(nb_q - 4'd3 * {2'b00, dr});
	logic          nb_skip;
	logic [RW-1:0] nr;
	logic [CW-1:0] nc;
	logic [AW:0]   nb_addr;
	always_comb begin
		nb_skip = (nb_q == 4'd4) || (dr == 2'd0 && r_q == '0)
			|| (dr == 2'd2 && r_q == act_rows - RW'(1));
		nr = (dr == 2'd0) ? r_q - RW'(1) : (dr == 2'd2) ? r_q + RW'(1) : r_q;
		if (dc == 2'd0) nc = (c_q == '0) ? act_cols - CW'(1) : c_q - CW'(1);
		else if (dc == 2'd2) nc = (c_q == act_cols - CW'(1)) ? '0 : c_q + CW'(1);
		else nc = c_q;
		nb_addr = (AW+1)'(nr * act_cols) + (AW+1)'(nc);
	end

	// banks
	logic                    we_a, we_b;
	logic [AW-1:0]           ram_addr;
	logic [HEIGHT_BITS-1:0]  wdata, rd_a, rd_b, rd_src;
	logic                    wr_en, wr_dst;  // wr_dst: 1 writes other bank
	assign rd_src = bank_q ? rd_b : rd_a;
	assign we_a   = wr_en && ((bank_q ^ wr_dst) == 1'b0);
	assign we_b   = wr_en && ((bank_q ^ wr_dst) == 1'b1);

	teg_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_bank_a (
		.clk(clk), .we(we_a), .addr(ram_addr), .wdata(wdata), .rdata(rd_a));
	teg_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_bank_b (
		.clk(clk), .we(we_b), .addr(ram_addr), .wdata(wdata), .rdata(rd_b));

	// shared unit: excess flow for one neighbor
	logic signed [LIMIT_W:0]  limit;
	logic signed [DIF_W-1:0]  diff, ex_give, ex_take;
	logic signed [ACC_W-1:0]  flow;
	always_comb begin
		limit = (dr == 2'd1 || dc == 2'd1) ? $signed({1'b0, lim_o_q})
			: $signed({1'b0, lim_d_q});
		diff    = DIF_W'(here_q) - DIF_W'($signed(rd_src));
		ex_give = diff - DIF_W'(limit);
		ex_take = -diff - DIF_W'(limit);
		if (ex_give > 0) flow = -ACC_W'(ex_give >>> 4);
		else if (ex_take > 0) flow = ACC_W'(ex_take >>> 4);
		else flow = '0;
	end

	// saturated new height
	localparam logic signed [ACC_W-1:0] HMAX = ACC_W'({1'b0, {(HEIGHT_BITS-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] HMIN = -HMAX - ACC_W'(1);
	logic signed [ACC_W-1:0] new_sum;
	logic [HEIGHT_BITS-1:0]  new_h;
	always_comb begin
		new_sum = ACC_W'(here_q) + net_q;
		if (new_sum > HMAX) new_h = HEIGHT_BITS'(HMAX);
		else if (new_sum < HMIN) new_h = HEIGHT_BITS'(HMIN);
		else new_h = HEIGHT_BITS'(new_sum);
	end

	// write value: sign extend/saturate 32-bit input to HEIGHT_BITS
	localparam int unsigned XW = (HEIGHT_BITS > IO_H_W) ? HEIGHT_BITS : IO_H_W;
	logic signed [XW-1:0] win_x, hmax_x, rd_x;
	logic [HEIGHT_BITS-1:0] win_sat;
	logic signed [IO_H_W-1:0] rd_sat;
	localparam logic signed [XW-1:0] I32MAX = XW'(33'sh07FFFFFFF);
	always_comb begin
		win_x  = XW'(cmd.height_in);
		hmax_x = XW'(HMAX);
		if (win_x > hmax_x) win_sat = HEIGHT_BITS'(hmax_x);
		else if (win_x < -hmax_x - XW'(1)) win_sat = HEIGHT_BITS'(-hmax_x - XW'(1));
		else win_sat = HEIGHT_BITS'(win_x);
		rd_x = XW'($signed(rd_src));
		if (rd_x > I32MAX) rd_sat = IO_H_W'(I32MAX);
		else if (rd_x < -I32MAX - XW'(1)) rd_sat = IO_H_W'(-I32MAX - XW'(1));
		else rd_sat = IO_H_W'(rd_x);
	end

	logic cmd_fire;
	assign cmd_fire = cmd.valid && cmd.ready;
	logic last_cell, last_nb;
	assign last_cell = (lin_q == act_cells - (AW+1)'(1));
	assign last_nb   = (nb_q == 4'd8);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd.valid) begin
				unique case (func_t'(cmd.func))
					FUNC_READ: state_d = (32'(cmd.cell_index) < DEPTH) ? ST_RD_WAIT
						: ST_RESPOND;
					FUNC_RUN:  state_d = ST_PASS_START;
					default:   state_d = ST_RESPOND;
				endcase
			end
			ST_RD_WAIT:    state_d = ST_RD_DATA;
			ST_RD_DATA:    state_d = ST_RESPOND;
			ST_PASS_START: state_d = (pass_q == passes_q) ? ST_RESPOND : ST_CELL_REQ;
			ST_CELL_REQ:   state_d = ST_CELL_WAIT;
			ST_CELL_WAIT:  state_d = ST_CELL_LOAD;
			ST_CELL_LOAD:  state_d = ST_NB_REQ;
			ST_NB_REQ:     state_d = nb_skip ? (last_nb ? ST_CELL_WRITE : ST_NB_REQ)
				: ST_NB_WAIT;
			ST_NB_WAIT:    state_d = ST_NB_ACC;
			ST_NB_ACC:     state_d = last_nb ? ST_CELL_WRITE : ST_NB_REQ;
			ST_CELL_WRITE: state_d = last_cell
				? ((act_cells == (AW+1)'(DEPTH)) ? ST_PASS_END : ST_COPY_REQ)
				: ST_CELL_REQ;
			ST_COPY_REQ:   state_d = ST_COPY_WAIT;
			ST_COPY_WAIT:  state_d = ST_COPY_WRITE;
			ST_COPY_WRITE: state_d = (lin_q == (AW+1)'(DEPTH - 1)) ? ST_PASS_END
				: ST_COPY_REQ;
			ST_PASS_END:   state_d = ST_PASS_START;
			ST_RESPOND:    state_d = rsp.ready ? ST_IDLE : ST_RESPOND;
			default:       state_d = ST_IDLE;
		endcase
	end

	// memory port and handshake outputs; hold the address while read data waits
	always_comb begin
		ram_addr = '0;
		wdata    = win_sat;
		wr_en    = 1'b0;
		wr_dst   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ram_addr = AW'(cmd.cell_index);
				wr_en = cmd_fire && func_t'(cmd.func) == FUNC_WRITE
					&& 32'(cmd.cell_index) < DEPTH;
			end
			ST_RD_WAIT:    ram_addr = AW'(idx_q);
			ST_CELL_REQ:   ram_addr = AW'(lin_q);
			ST_CELL_WAIT:  ram_addr = AW'(lin_q);
			ST_NB_REQ:     ram_addr = AW'(nb_addr);
			ST_NB_WAIT:    ram_addr = AW'(nb_addr);
			ST_CELL_WRITE: begin
				ram_addr = AW'(lin_q); wdata = new_h; wr_en = 1'b1; wr_dst = 1'b1;
			end
			ST_COPY_REQ:   ram_addr = AW'(lin_q);
			ST_COPY_WAIT:  ram_addr = AW'(lin_q);
			ST_COPY_WRITE: begin
				ram_addr = AW'(lin_q); wdata = rd_src; wr_en = 1'b1; wr_dst = 1'b1;
			end
			default: ;
		endcase
	end

	assign cmd.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = (state_q == ST_RESPOND);
	assign rsp.height_out = hout_q;
	assign rsp.op_done    = done_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bank_q  <= 1'b0;
			pass_q  <= '0;
			r_q     <= '0;
			c_q     <= '0;
			lin_q   <= '0;
			nb_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: if (cmd_fire) begin
					done_q <= (func_t'(cmd.func) != FUNC_NONE);
					pass_q <= '0;
				end
				ST_PASS_START: begin
					r_q <= '0; c_q <= '0; lin_q <= '0;
				end
				ST_CELL_LOAD: nb_q <= '0;
				ST_NB_REQ: if (nb_skip && !last_nb) nb_q <= nb_q + 4'd1;
				ST_NB_ACC: nb_q <= nb_q + 4'd1;
				ST_CELL_WRITE: begin
					lin_q <= lin_q + (AW+1)'(1);
					if (c_q == act_cols - CW'(1)) begin
						c_q <= '0; r_q <= r_q + RW'(1);
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				ST_COPY_WRITE: lin_q <= lin_q + (AW+1)'(1);
				ST_PASS_END: begin
					bank_q <= ~bank_q;
					pass_q <= pass_q + 8'd1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (cmd_fire) begin
				idx_q  <= cmd.cell_index;
				hout_q <= '0;
			end
			ST_RD_DATA:   hout_q <= rd_sat;
			ST_CELL_LOAD: begin
				here_q <= rd_src;
				net_q  <= '0;
			end
			ST_NB_ACC:    net_q <= net_q + flow;
			default: ;
		endcase
	end
endmodule

### src/teg_checker.sv
// ----------------------------------------------------------------------------
// teg_checker: port-level checks for the erosion unit
// Watches the command and response channels over time.
// ----------------------------------------------------------------------------
module teg_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready
);
	// a command is never taken while a response waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !cmd_ready) else $error("command taken during response");

	// after an accepted command the block is not ready for another in the cycle after
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready) else $error("ready after transfer");

	// a response holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");

	// after a response transfer the block is ready again
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready) |=> cmd_ready) else $error("not idle after response");
endmodule

bind thermal_erosion_grid_pass_unit teg_checker u_teg_checker (
	.clk(clk), .arst_n(arst_n),
	.cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready));

### tb/teg_scoreboard.sv
// ----------------------------------------------------------------------------
// teg_scoreboard: expected-response tracker for the thermal erosion unit
// Mirrors both height banks, the register file and the erosion pass, and
// compares every response with the oldest predicted one.
// ----------------------------------------------------------------------------
package teg_scoreboard_pkg;
	import teg_pkg::*;

	localparam int unsigned CELLS = DEF_MAX_COLUMNS * DEF_MAX_ROWS;

	typedef struct {
		logic signed [IO_H_W-1:0] height;
		logic                     done;
	} response_t;

	class erosion_scoreboard;
		longint      height_mem[2][CELLS];
		bit          written[2][CELLS];
		bit          cur_bank;
		int unsigned grid_cols;
		int unsigned grid_rows;
		longint      lim_ort;
		longint      lim_dia;
		int unsigned passes;
		response_t   pending_results[$];
		int          errors;

		function new();
			cur_bank  = 0;
			grid_cols = 128;
			grid_rows = 128;
			lim_ort   = 256;
			lim_dia   = 362;
			passes    = 1;
			errors    = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_COLUMNS: grid_cols = data[7:0];
				REG_ROWS:    grid_rows = data[7:0];
				REG_LIM_ORT: lim_ort = longint'(data[LIMIT_W-1:0]);
				REG_LIM_DIA: lim_dia = longint'(data[LIMIT_W-1:0]);
				REG_PASSES:  passes = data[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned active_cols();
			if (grid_cols < 1) return 1;
			if (grid_cols > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
			return grid_cols;
		endfunction

		function int unsigned active_rows();
			if (grid_rows < 1) return 1;
			if (grid_rows > DEF_MAX_ROWS) return DEF_MAX_ROWS;
			return grid_rows;
		endfunction

		function bit is_written(int unsigned a);
			return written[cur_bank][a];
		endfunction

		// one pass: frozen source bank, new heights into the other bank
		function void erode_once();
			int     cols, rows, r, c, dr, dc, nr, nc;
			bit     sb, db;
			longint here, there, net, lim, ex, hmax, hmin;
			cols = active_cols();
			rows = active_rows();
			sb   = cur_bank;
			db   = !cur_bank;
			hmax = 64'sd2147483647;
			hmin = -hmax - 1;
			for (r = 0; r < rows; r++) begin
				for (c = 0; c < cols; c++) begin
					here = height_mem[sb][r * cols + c];
					net  = 0;
					for (dr = -1; dr <= 1; dr++) begin
						nr = r + dr;
						if (nr < 0 || nr >= rows) continue;
						for (dc = -1; dc <= 1; dc++) begin
							if (dr == 0 && dc == 0) continue;
							nc = c + dc;
							if (nc < 0) nc += cols;
							if (nc >= cols) nc -= cols;
							there = height_mem[sb][nr * cols + nc];
							lim   = (dr == 0 || dc == 0) ? lim_ort : lim_dia;
							ex    = here - there - lim;
							if (ex > 0) net -= ex >>> 4;
							ex = there - here - lim;
							if (ex > 0) net += ex >>> 4;
						end
					end
					here += net;
					if (here > hmax) here = hmax;
					if (here < hmin) here = hmin;
					height_mem[db][r * cols + c] = here;
					written[db][r * cols + c]    = 1;
				end
			end
			for (int a = cols * rows; a < CELLS; a++) begin
				height_mem[db][a] = height_mem[sb][a];
				written[db][a]    = written[sb][a];
			end
			cur_bank = db;
		endfunction

		// predict the response of one accepted command
		function void note_command(func_t f, logic [INDEX_W-1:0] idx,
				logic signed [IO_H_W-1:0] h);
			response_t rsp;
			rsp.height = '0;
			rsp.done   = 1;
			case (f)
				FUNC_WRITE: begin
					height_mem[cur_bank][idx] = longint'(h);
					written[cur_bank][idx]    = 1;
				end
				FUNC_RUN: begin
					for (int p = 0; p < passes; p++) erode_once();
				end
				FUNC_READ: rsp.height = height_mem[cur_bank][idx][IO_H_W-1:0];
				default: rsp.done = 0;
			endcase
			pending_results.push_back(rsp);
		endfunction

		function void check_response(logic signed [IO_H_W-1:0] h, logic d);
			response_t exp_rsp;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response height_out=%0d op_done=%0b",
					$realtime, h, d);
				errors++;
				return;
			end
			exp_rsp = pending_results.pop_front();
			if (h !== exp_rsp.height) begin
				$display("%0t: height_out mismatch expected=%0d actual=%0d",
					$realtime, exp_rsp.height, h);
				errors++;
			end
			if (d !== exp_rsp.done) begin
				$display("%0t: op_done mismatch expected=%0b actual=%0b",
					$realtime, exp_rsp.done, d);
				errors++;
			end
		endfunction
	endclass

endpackage

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top-level check of the thermal erosion grid pass unit
// Loads small grids through the command channel, runs erosion passes under
// several register settings and checks every response against a predictor.
// ----------------------------------------------------------------------------
module testbench;
	import teg_pkg::*;
	import teg_scoreboard_pkg::*;

	logic clk;
	logic arst_n;

	teg_cmd_if cmd_ch ();
	teg_rsp_if rsp_ch ();
	teg_cfg_if cfg_ch ();

	erosion_scoreboard sb;

	thermal_erosion_grid_pass_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 0;
		forever #10 clk = !clk;
	end

	// hard stop for a hung run
	initial begin
		#60000000;
		$display("thermal_erosion_grid_pass_unit test failed");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [IO_H_W-1:0] pick_height();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 0;
				default: return -1;
			endcase
		end
		if (r == 1) return $urandom;
		return $signed($urandom_range(0, 8192)) - 4096;
	endfunction

	task automatic send_cmd(func_t f, logic [INDEX_W-1:0] idx,
			logic signed [IO_H_W-1:0] h);
		int unsigned g;
		g = gap_len();
		if (g > 0) begin
			cmd_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
		cmd_ch.valid      <= 1;
		cmd_ch.func       <= f;
		cmd_ch.cell_index <= idx;
		cmd_ch.height_in  <= h;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_command(f, idx, h);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] data);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_register(idx, data);
		cfg_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		cmd_ch.valid <= 0;
		while (sb.pending_results.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// fill every active cell so that a pass never reads an unwritten one
	task automatic load_grid();
		int unsigned n;
		n = sb.active_cols() * sb.active_rows();
		for (int unsigned a = 0; a < n; a++)
			send_cmd(FUNC_WRITE, INDEX_W'(a), pick_height());
	endtask

	task automatic random_items(int unsigned count, int unsigned runs);
		int unsigned n, a, r, done_runs;
		done_runs = 0;
		n = sb.active_cols() * sb.active_rows();
		for (int unsigned i = 0; i < count; i++) begin
			if (done_runs < runs && i >= count * (done_runs + 1) / (runs + 1)) begin
				send_cmd(FUNC_RUN, INDEX_W'($urandom), $urandom);
				done_runs++;
			end
			r = $urandom_range(0, 99);
			if (r < 45) begin
				a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, CELLS - 1)
					: $urandom_range(0, n - 1);
				send_cmd(FUNC_WRITE, INDEX_W'(a), pick_height());
			end else if (r < 95) begin
				a = $urandom_range(0, CELLS - 1);
				if (!sb.is_written(a)) a = $urandom_range(0, n - 1);
				send_cmd(FUNC_READ, INDEX_W'(a), $urandom);
			end else begin
				send_cmd(FUNC_NONE, INDEX_W'($urandom), $urandom);
			end
		end
	endtask

	// response side: long hold-off first, then random stalls
	initial begin
		int unsigned g;
		rsp_ch.ready <= 0;
		wait (arst_n);
		repeat (150) @(posedge clk);
		forever begin
			rsp_ch.ready <= 1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			g = gap_len();
			if (g > 0) begin
				rsp_ch.ready <= 0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// check each response transfer
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.height_out, rsp_ch.op_done);
	end

	initial begin
		sb = new();
		arst_n            <= 0;
		cmd_ch.valid      <= 0;
		cmd_ch.func       <= FUNC_WRITE;
		cmd_ch.cell_index <= '0;
		cmd_ch.height_in  <= '0;
		cfg_ch.valid      <= 0;
		cfg_ch.index      <= REG_COLUMNS;
		cfg_ch.data       <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every func, zero-pass run
		write_reg(REG_COLUMNS, 3);
		write_reg(REG_ROWS, 2);
		write_reg(REG_PASSES, 0);
		load_grid();
		send_cmd(FUNC_WRITE, 14'h3fff, 32'sh7fffffff);
		send_cmd(FUNC_READ, 14'h3fff, 0);
		send_cmd(FUNC_WRITE, 14'h3ffe, 32'sh80000000);
		send_cmd(FUNC_READ, 14'h3ffe, 32'sh7fffffff);
		send_cmd(FUNC_WRITE, 0, 0);
		send_cmd(FUNC_READ, 0, -1);
		send_cmd(FUNC_NONE, 14'h3fff, -1);
		send_cmd(FUNC_NONE, 0, 0);
		send_cmd(FUNC_RUN, 0, 0);
		send_cmd(FUNC_READ, 0, 0);
		send_cmd(FUNC_WRITE, 1, -1);
		send_cmd(FUNC_READ, 1, 0);
		random_items(120, 2);
		drain();

		// one column, full height
		write_reg(REG_COLUMNS, 1);
		write_reg(REG_ROWS, 128);
		write_reg(REG_LIM_ORT, 0);
		write_reg(REG_LIM_DIA, 0);
		write_reg(REG_PASSES, 1);
		load_grid();
		random_items(60, 1);
		drain();

		// oversized column count saturates, maximum limits
		write_reg(REG_COLUMNS, 255);
		write_reg(REG_ROWS, 1);
		write_reg(REG_LIM_ORT, 32'h7fffffff);
		write_reg(REG_LIM_DIA, 32'hffffffff);
		load_grid();
		random_items(60, 1);
		drain();

		// two columns: left and right are the same cell
		write_reg(REG_COLUMNS, 2);
		write_reg(REG_ROWS, 3);
		write_reg(REG_LIM_ORT, 40);
		write_reg(REG_LIM_DIA, 57);
		write_reg(REG_PASSES, 2);
		load_grid();
		random_items(130, 1);
		drain();

		// zero-size grid counts as a single cell
		write_reg(REG_COLUMNS, 0);
		write_reg(REG_ROWS, 0);
		write_reg(REG_LIM_ORT, 100);
		write_reg(REG_LIM_DIA, 141);
		write_reg(REG_PASSES, 1);
		load_grid();
		random_items(100, 1);
		drain();

		// small grid, random limits, one pass per run
		write_reg(REG_PASSES, 255);
		write_reg(REG_COLUMNS, 5);
		write_reg(REG_ROWS, 4);
		write_reg(REG_LIM_ORT, $urandom_range(0, 2000));
		write_reg(REG_LIM_DIA, $urandom_range(0, 2800));
		write_reg(REG_PASSES, 1);
		load_grid();
		random_items(70, 3);

		// wait out the tail
		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("thermal_erosion_grid_pass_unit test passed");
		end else begin
			$display("thermal_erosion_grid_pass_unit test failed");
		end
		$finish;
	end

endmodule
